// ===== design/b32d_pkg.sv =====
// Shared types and constants for the base32 stream decoder.
// No dependencies; used by every module of the block.
package b32d_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADCHAR = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_DIGIT_2 = 8'h32;
  localparam logic [7:0] CH_DIGIT_7 = 8'h37;
  // '2' maps to 26, so subtract '2' - 26
  localparam logic [7:0] DIGIT_OFFSET = 8'd24;

  localparam int unsigned GROUP_BYTES   = 5;
  localparam int unsigned GROUP_SYMBOLS = 8;

  localparam logic [15:0] CAPACITY_RESET = 16'd1024;

  typedef struct packed {
    logic [39:0] group;   // five bytes, first byte in the top bits
    logic [1:0]  status;  // ST_OK: five bytes; otherwise one error result
    logic        last;
  } job_t;

endpackage

// ===== design/b32d_queue.sv =====
// Short job queue between the decoder front and the byte serializer.
// Depends on b32d_pkg (job_t).
module b32d_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  b32d_pkg::job_t push_job,
  input  logic          pop,
  output b32d_pkg::job_t head_job,
  output logic          not_empty,
  output logic          has_space
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  b32d_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_job  = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign has_space = (count != CNT_FULL);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> has_space) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("queue pop while empty");

endmodule

// ===== design/b32d_front.sv =====
// Decoder front: takes characters, maps symbols, builds groups,
// checks capacity and queues byte groups or error jobs. Depends on b32d_pkg.
module b32d_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     char_code,
  input  logic           last_char,
  output logic           in_ready,
  input  logic [15:0]    capacity,
  input  logic           queue_space,
  output logic           push,
  output b32d_pkg::job_t push_job
);

  logic [39:0] symbol_group;
  logic [2:0]  symbol_count;
  logic [15:0] bytes_used;
  logic        discarding;

  logic        accept;
  logic        is_alpha;
  logic        is_digit;
  logic        sym_ok;
  logic [7:0]  sym_wide;
  logic [4:0]  sym;
  logic [39:0] group_next;
  logic        complete;
  logic        no_space;

  assign in_ready = queue_space;
  assign accept   = in_valid && queue_space;

  assign is_alpha = (char_code >= b32d_pkg::CH_UPPER_A) && (char_code <= b32d_pkg::CH_UPPER_Z);
  assign is_digit = (char_code >= b32d_pkg::CH_DIGIT_2) && (char_code <= b32d_pkg::CH_DIGIT_7);
  assign sym_ok   = is_alpha || is_digit;
  assign sym_wide = is_alpha ? (char_code - b32d_pkg::CH_UPPER_A)
                             : (char_code - b32d_pkg::DIGIT_OFFSET);
  assign sym      = sym_wide[4:0];

  always_comb begin
    group_next = symbol_group;
    for (int i = 0; i < 8; i++) begin
      if (symbol_count == 3'(i)) begin
        group_next[39-5*i -: 5] = sym;
      end
    end
  end

  assign complete = (symbol_count == 3'd7) || last_char;
  assign no_space = ({1'b0, bytes_used} + 17'd5) > {1'b0, capacity};

  always_comb begin
    push            = 1'b0;
    push_job.group  = group_next;
    push_job.status = b32d_pkg::ST_OK;
    push_job.last   = last_char;
    if (accept && !discarding) begin
      if (!sym_ok) begin
        push            = 1'b1;
        push_job.group  = '0;
        push_job.status = b32d_pkg::ST_BADCHAR;
        push_job.last   = 1'b1;
      end else if (complete) begin
        push = 1'b1;
        if (no_space) begin
          push_job.group  = '0;
          push_job.status = b32d_pkg::ST_NOSPACE;
          push_job.last   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_group <= '0;
      symbol_count <= '0;
      bytes_used   <= '0;
      discarding   <= 1'b0;
    end else if (accept) begin
      if (discarding) begin
        if (last_char) begin
          discarding <= 1'b0;
        end
      end else if (!sym_ok || (complete && no_space)) begin
        symbol_group <= '0;
        symbol_count <= '0;
        bytes_used   <= '0;
        discarding   <= !last_char;
      end else if (complete) begin
        symbol_group <= '0;
        symbol_count <= '0;
        bytes_used   <= last_char ? '0 : bytes_used + 16'd5;
      end else begin
        symbol_group <= group_next;
        symbol_count <= symbol_count + 1'b1;
      end
    end
  end

  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    discarding |-> !push) else $error("job queued while discarding");
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (push && push_job.status != b32d_pkg::ST_OK) |-> push_job.last)
    else $error("error job without last mark");

endmodule

// ===== design/b32d_back.sv =====
// Byte serializer: pops jobs from the queue and drives the output register,
// one result per cycle while the receiver is ready. Depends on b32d_pkg.
module b32d_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_avail,
  input  b32d_pkg::job_t head_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     data_byte,
  output logic [1:0]     status,
  output logic           last_result
);

  b32d_pkg::job_t cur;
  logic           cur_valid;
  logic [2:0]     idx;

  logic       emit;
  logic       is_err;
  logic       done;
  logic [7:0] sel_byte;

  assign emit   = cur_valid && (!out_valid || out_ready);
  assign is_err = (cur.status != b32d_pkg::ST_OK);
  assign done   = emit && (is_err || idx == 3'(b32d_pkg::GROUP_BYTES - 1));
  assign pop    = job_avail && (!cur_valid || done);

  always_comb begin
    unique case (idx)
      3'd0:    sel_byte = cur.group[39:32];
      3'd1:    sel_byte = cur.group[31:24];
      3'd2:    sel_byte = cur.group[23:16];
      3'd3:    sel_byte = cur.group[15:8];
      default: sel_byte = cur.group[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur       <= head_job;
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        idx <= idx + 1'b1;
      end

      if (emit) begin
        out_valid   <= 1'b1;
        data_byte   <= is_err ? 8'd0 : sel_byte;
        status      <= cur.status;
        last_result <= is_err || (cur.last && idx == 3'(b32d_pkg::GROUP_BYTES - 1));
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx < 3'(b32d_pkg::GROUP_BYTES))) else $error("byte index out of range");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != b32d_pkg::ST_OK) |-> (last_result && data_byte == 8'd0))
    else $error("error result malformed");

endmodule

// ===== design/base32_stream_decoder.sv =====
// Top level of the base32 stream decoder: config register, front, queue, back.
// Depends on b32d_pkg, b32d_front, b32d_queue, b32d_back.
//
// Input channel s_axis: one ASCII character per item, tlast on the final
// character of a string. Output channel m_axis: one decoded byte per item,
// tuser carries the status (ok, invalid character, no space), tlast marks the
// final result of a string. cfg_we/cfg_wdata write capacity_bytes.
// Throughput: one character per cycle in while the queue has space, one result
// per cycle out while the receiver is ready. A group of eight characters
// yields five bytes, so the output keeps up; a string of many short final
// groups is paced by the output, which gives five bytes per group.
// The first byte of a group passes from the queue into the serializer's job
// register and then into the output register. The queue holds QUEUE_DEPTH
// jobs; s_axis_tready drops only when it is full, so a stalled receiver backs
// up the queue first and then the input. Reset clears the string state, the
// queue and the output, and sets the capacity to 1024 bytes.
module base32_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0]    capacity;
  logic           push;
  b32d_pkg::job_t push_job;
  logic           pop;
  b32d_pkg::job_t head_job;
  logic           not_empty;
  logic           has_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= b32d_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  b32d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .char_code   (s_axis_tdata),
    .last_char   (s_axis_tlast),
    .in_ready    (s_axis_tready),
    .capacity    (capacity),
    .queue_space (has_space),
    .push        (push),
    .push_job    (push_job)
  );

  b32d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .not_empty (not_empty),
    .has_space (has_space)
  );

  b32d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_avail   (not_empty),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .data_byte   (m_axis_tdata),
    .status      (m_axis_tuser),
    .last_result (m_axis_tlast)
  );

endmodule

// ===== tb/sv/base32_result_checker.sv =====
`timescale 1ns / 100ps
// Checker for the base32 stream decoder: predicts decoded bytes from the input items.
// Compares them with the output items. Depends on b32d_pkg.
module base32_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic [1:0]  out_status,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          outstanding
);

  localparam int MAX_REPORTS = 10;
  localparam int SYM_DIGIT_BASE = 26;
  localparam int SYM_BITS = 5;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } decoded_t;

  decoded_t    decoded_due[$];
  logic [15:0] capacity;
  logic [39:0] group_bits;
  int          group_syms;
  logic [15:0] string_bytes;
  logic        swallowing;
  int          fails;

  initial begin
    fails = 0;
  end

  function automatic int symbol_of(input logic [7:0] ch);
    if (ch >= b32d_pkg::CH_UPPER_A && ch <= b32d_pkg::CH_UPPER_Z) begin
      return int'(ch) - int'(b32d_pkg::CH_UPPER_A);
    end
    if (ch >= b32d_pkg::CH_DIGIT_2 && ch <= b32d_pkg::CH_DIGIT_7) begin
      return int'(ch) - int'(b32d_pkg::CH_DIGIT_2) + SYM_DIGIT_BASE;
    end
    return -1;
  endfunction

  function automatic void close_string();
    group_bits = '0;
    group_syms = 0;
    string_bytes = '0;
  endfunction

  function automatic void abort_string(input logic [1:0] status, input logic lst);
    decoded_t err;
    err = '{8'h00, status, 1'b1};
    decoded_due.push_back(err);
    close_string();
    swallowing = !lst;
  endfunction

  function automatic void decode_char(input logic [7:0] ch, input logic lst);
    int          sym;
    logic [39:0] padded;
    decoded_t    res;
    if (swallowing) begin
      if (lst) begin
        swallowing = 1'b0;
      end
      return;
    end
    sym = symbol_of(ch);
    if (sym < 0) begin
      abort_string(b32d_pkg::ST_BADCHAR, lst);
      return;
    end
    group_bits = {group_bits[39-SYM_BITS:0], sym[SYM_BITS-1:0]};
    group_syms++;
    if (group_syms < int'(b32d_pkg::GROUP_SYMBOLS) && !lst) begin
      return;
    end
    padded = group_bits << (SYM_BITS * (int'(b32d_pkg::GROUP_SYMBOLS) - group_syms));
    if (int'(string_bytes) + int'(b32d_pkg::GROUP_BYTES) > int'(capacity)) begin
      abort_string(b32d_pkg::ST_NOSPACE, lst);
      return;
    end
    for (int k = 0; k < int'(b32d_pkg::GROUP_BYTES); k++) begin
      res = '{padded[39-8*k -: 8], b32d_pkg::ST_OK,
              lst && (k == int'(b32d_pkg::GROUP_BYTES) - 1)};
      decoded_due.push_back(res);
    end
    string_bytes = string_bytes + 16'(b32d_pkg::GROUP_BYTES);
    group_bits = '0;
    group_syms = 0;
    if (lst) begin
      close_string();
    end
  endfunction

  function automatic void flag(input string what, input decoded_t want, input decoded_t got);
    if (fails < MAX_REPORTS) begin
      $display("%0t: %s: expected data %02h status %0d last %0b, got data %02h status %0d last %0b",
               $realtime, what, want.data, want.status, want.last,
               got.data, got.status, got.last);
    end
    fails++;
  endfunction

  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (rst) begin
      capacity = b32d_pkg::CAPACITY_RESET;
      swallowing = 1'b0;
      close_string();
      decoded_due.delete();
    end else begin
      if (cfg_we) begin
        capacity = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        decode_char(in_char, in_last);
      end
      if (out_valid && out_ready) begin
        got = '{out_byte, out_status, out_last};
        if (decoded_due.size() == 0) begin
          flag("unexpected item", '0, got);
        end else begin
          want = decoded_due.pop_front();
          if (got !== want) begin
            flag("mismatch", want, got);
          end
        end
      end
    end
    fail_count <= fails;
    outstanding <= decoded_due.size();
  end

endmodule

// ===== tb/sv/base32_stream_decoder_test.sv =====
`timescale 1ns / 100ps
// Top of the base32 stream decoder testbench: clock, reset, stimulus, verdict.
// Depends on b32d_pkg, base32_stream_decoder and base32_result_checker.
module base32_stream_decoder_test;

  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS = 42;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_COMB} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'h0000;

  int       fail_count;
  int       outstanding;
  int       burst_left = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  always #5 clk = ~clk;

  base32_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  base32_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_char     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_byte    (m_axis_tdata),
    .out_status  (m_axis_tuser),
    .out_last    (m_axis_tlast),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // receiver backpressure: a mode held for a random stretch
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: m_axis_tready <= 1'b1;
      RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SLOW: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_tick[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tlast <= lst;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_text(input string txt, input logic close);
    for (int i = 0; i < txt.len(); i++) begin
      send_char(txt[i], close && (i == txt.len() - 1));
    end
  endtask

  // wait until every expected byte is out and the pipeline is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] any_symbol();
    int v;
    v = $urandom_range(0, 31);
    return (v < 26) ? b32d_pkg::CH_UPPER_A + 8'(v) : b32d_pkg::CH_DIGIT_2 + 8'(v - 26);
  endfunction

  function automatic logic [7:0] any_non_symbol();
    string      odd;
    logic [7:0] ch;
    odd = "=0189 \t\n\r";
    case ($urandom_range(0, 2))
      0: ch = "a" + 8'($urandom_range(0, 25));
      1: ch = odd[$urandom_range(0, odd.len() - 1)];
      default: begin
        do begin
          ch = 8'($urandom_range(0, 255));
        end while ((ch >= b32d_pkg::CH_UPPER_A && ch <= b32d_pkg::CH_UPPER_Z) ||
                   (ch >= b32d_pkg::CH_DIGIT_2 && ch <= b32d_pkg::CH_DIGIT_7));
      end
    endcase
    return ch;
  endfunction

  // mostly well-formed strings, some with a bad character, a few pure noise
  task automatic send_random_string(output int counted);
    int  kind;
    int  len;
    int  bad_at;
    bit  noise;
    logic [7:0] ch;
    kind = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
    noise = (kind >= 92);
    bad_at = (kind < 20) ? $urandom_range(0, len - 1) : len;
    counted = 0;
    for (int i = 0; i < len; i++) begin
      if (noise) begin
        ch = 8'($urandom_range(0, 255));
      end else if (i == bad_at) begin
        ch = any_non_symbol();
      end else begin
        ch = any_symbol();
      end
      send_char(ch, i == len - 1);
      counted++;
    end
  endtask

  initial begin
    int          sent;
    int          n;
    logic [15:0] caps [7];
    caps = '{16'd65535, 16'd0, 16'd5, 16'd40, 16'd13, 16'd1024, 16'd0};
    caps[6] = 16'($urandom_range(0, 65535));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // full group closed by the last char, padded partial group
    send_text("77777777", 1'b1);
    send_text("AB2", 1'b1);
    // bad char mid-string, rest swallowed through tlast
    send_text("ZaQB", 1'b1);
    // bad char on the last item of a string
    send_text("=", 1'b1);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);

    // capacity lowered below the bytes already used in an open string
    settle();
    write_capacity(16'd5);
    send_text("MZXW6YTB", 1'b0);
    settle();
    write_capacity(16'd3);
    send_text("OQ", 1'b1);

    for (int p = 0; p < 7; p++) begin
      settle();
      write_capacity(caps[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_string(n);
        sent += n;
      end
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/b32d_pkg.sv
design/b32d_queue.sv
design/b32d_front.sv
design/b32d_back.sv
design/base32_stream_decoder.sv
tb/sv/base32_result_checker.sv
tb/sv/base32_stream_decoder_test.sv
